// ===== hw/rtl/kvsa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kvsa_pkg: shared types and constants of the KV cache slot addresser
// Field widths, command and status codes, register indexes and the words
// that travel between the front end, the command queue and the back end.
// ----------------------------------------------------------------------------
package kvsa_pkg;

   localparam int CMD_W     = 3;
   localparam int LAYER_W   = 7;
   localparam int HEAD_W    = 6;
   localparam int POS_W     = 20;
   localparam int FILL_W    = 21;
   localparam int STATUS_W  = 3;
   localparam int VEC_W     = 10;
   localparam int HCNT_W    = 7;
   localparam int LCNT_W    = 8;
   localparam int PROD_W    = FILL_W + HEAD_W;    // padded_length * head
   localparam int BASE_W    = PROD_W + 1;         // plus position
   localparam int DATA_W    = 37;
   localparam int SCALE_W   = 31;
   localparam int SCNT_W    = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 21;

   localparam logic [FILL_W-1:0] POSITION_LIMIT = FILL_W'(1048576);
   localparam logic [VEC_W-1:0]  VECTOR_LIMIT   = VEC_W'(512);
   localparam int                QUANT_SHIFT    = 6;  // 64 elements per scale

   typedef enum logic [CMD_W-1:0] {
      CMD_READ    = 3'd0,
      CMD_APPEND  = 3'd1,
      CMD_ADVANCE = 3'd2,
      CMD_REWIND  = 3'd3,
      CMD_RESET   = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 3'd0,
      ST_BAD_LAYER   = 3'd1,
      ST_BAD_HEAD    = 3'd2,
      ST_NOT_WRITTEN = 3'd3,
      ST_BEYOND_CAP  = 3'd4,
      ST_FULL        = 3'd5,
      ST_REWIND_FWD  = 3'd6
   } status_type;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LENGTH    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PADDED_LENGTH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAD_COUNT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VECTOR_LENGTH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_EIGHT_BIT     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LAYERS        = 3'd5;

   typedef struct packed {
      logic [FILL_W-1:0] max_length;
      logic [FILL_W-1:0] padded_length;
      logic [HCNT_W-1:0] head_count;
      logic [VEC_W-1:0]  vector_length;
      logic              eight_bit_mode;
      logic [LCNT_W-1:0] layers_in_use;
   } cfg_type;

   // Classified command word from the front end
   typedef struct packed {
      status_type         status;
      logic               addr_ok;
      logic [POS_W-1:0]   pos;
      logic [LAYER_W-1:0] layer;
      logic [HEAD_W-1:0]  head;
      logic [FILL_W-1:0]  write_pointer;
   } mid_word_type;

   typedef struct packed {
      status_type          status;
      logic [POS_W-1:0]    slot_position;
      logic [LAYER_W-1:0]  layer_out;
      logic [DATA_W-1:0]   data_offset;
      logic [SCALE_W-1:0]  scale_offset;
      logic [SCNT_W-1:0]   scale_count;
      logic [FILL_W-1:0]   write_pointer;
   } rsp_word_type;

endpackage
`default_nettype wire

// ===== hw/rtl/kvsa_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kvsa_front: command front end
// Owns the fill position, checks each command against the registers and
// pushes a classified word into the command queue.
// ----------------------------------------------------------------------------
module kvsa_front (
   input  wire                          clock,
   input  wire                          reset,
   input  kvsa_pkg::cfg_type            cfg,
   input  wire                          push,
   output logic                         full,
   input  wire  [kvsa_pkg::CMD_W-1:0]   req_command,
   input  wire  [kvsa_pkg::LAYER_W-1:0] req_layer_sel,
   input  wire  [kvsa_pkg::HEAD_W-1:0]  req_head_sel,
   input  wire  [kvsa_pkg::POS_W-1:0]   req_target_position,
   input  wire                          q_full,
   output logic                         q_push,
   output kvsa_pkg::mid_word_type       q_word
);
   import kvsa_pkg::*;

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              layer_bad, head_bad, is_full, target_beyond;
   logic [FILL_W-1:0] target_ext;

   assign full   = q_full;
   assign q_push = push && !q_full;

   assign target_ext    = {1'b0, req_target_position};
   assign layer_bad     = {1'b0, req_layer_sel} >= cfg.layers_in_use;
   assign head_bad      = {1'b0, req_head_sel} >= cfg.head_count;
   // capacity is min(max_length, POSITION_LIMIT)
   assign is_full       = (fill_ff >= cfg.max_length) || (fill_ff >= POSITION_LIMIT);
   assign target_beyond = target_ext >= cfg.max_length;

   always_comb begin
      fill_in         = fill_ff;
      q_word          = '0;
      q_word.status   = ST_OK;
      q_word.layer    = req_layer_sel;
      q_word.head     = req_head_sel;
      case (req_command)
         CMD_READ: begin
            if (target_ext >= fill_ff) begin
               q_word.status = ST_NOT_WRITTEN;
            end else if (layer_bad) begin
               q_word.status = ST_BAD_LAYER;
            end else if (head_bad) begin
               q_word.status = ST_BAD_HEAD;
            end else if (target_beyond) begin
               q_word.status = ST_BEYOND_CAP;
            end else begin
               q_word.addr_ok = 1'b1;
               q_word.pos     = req_target_position;
            end
         end
         CMD_APPEND: begin
            if (is_full) begin
               q_word.status = ST_FULL;
            end else if (layer_bad) begin
               q_word.status = ST_BAD_LAYER;
            end else if (head_bad) begin
               q_word.status = ST_BAD_HEAD;
            end else begin
               q_word.addr_ok = 1'b1;
               q_word.pos     = fill_ff[POS_W-1:0];
            end
         end
         CMD_ADVANCE: begin
            if (is_full) begin
               q_word.status = ST_FULL;
            end else begin
               fill_in = fill_ff + FILL_W'(1);
            end
         end
         CMD_REWIND: begin
            if (target_ext > fill_ff) begin
               q_word.status = ST_REWIND_FWD;
            end else begin
               fill_in = target_ext;
            end
         end
         CMD_RESET: begin
            fill_in = '0;
         end
         default: begin
         end
      endcase
      if (!q_word.addr_ok) begin
         q_word.layer = '0;
         q_word.head  = '0;
      end
      q_word.write_pointer = fill_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (q_push) begin
         fill_ff <= fill_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/kvsa_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kvsa_queue: two-entry command queue
// Decouples the front end from the back end so that each can stall alone.
// ----------------------------------------------------------------------------
module kvsa_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    wr_en,
   input  kvsa_pkg::mid_word_type wr_word,
   output logic                   q_full,
   input  wire                    rd_en,
   output kvsa_pkg::mid_word_type rd_word,
   output logic                   q_empty
);
   import kvsa_pkg::*;

   mid_word_type mem_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   count_ff, count_in;
   logic         do_wr, do_rd;

   assign q_full  = count_ff == 2'd2;
   assign q_empty = count_ff == 2'd0;
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && !q_empty;
   assign rd_word = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 2'd1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_wr) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_rd) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_word;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/kvsa_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kvsa_back: offset back end
// Takes classified words from the queue, registers the slot base as it pops
// a word, then forms the data and scale offsets from it, and holds results
// in a two-entry output queue.
// ----------------------------------------------------------------------------
module kvsa_back (
   input  wire                            clock,
   input  wire                            reset,
   input  kvsa_pkg::cfg_type              cfg,
   input  wire                            q_empty,
   input  kvsa_pkg::mid_word_type         q_word,
   output logic                           q_pop,
   output logic                           empty,
   input  wire                            pop,
   output logic [kvsa_pkg::STATUS_W-1:0]  rsp_status,
   output logic [kvsa_pkg::POS_W-1:0]     rsp_slot_position,
   output logic [kvsa_pkg::LAYER_W-1:0]   rsp_layer_out,
   output logic [kvsa_pkg::DATA_W-1:0]    rsp_data_offset,
   output logic [kvsa_pkg::SCALE_W-1:0]   rsp_scale_offset,
   output logic [kvsa_pkg::SCNT_W-1:0]    rsp_scale_count,
   output logic [kvsa_pkg::FILL_W-1:0]    rsp_write_pointer
);
   import kvsa_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_MUL  = 2'b10
   } back_state_type;

   back_state_type      state_ff, state_in;
   mid_word_type        work_ff;
   logic [BASE_W-1:0]   base_ff, base_in;
   logic [PROD_W-1:0]   stride_prod;
   logic [VEC_W-1:0]    vec_len;
   logic [SCNT_W-1:0]   groups;
   logic [DATA_W:0]     data_prod;
   logic [SCALE_W:0]    scale_prod;
   rsp_word_type        out_word, rd_word;
   rsp_word_type        out_mem_ff [2];
   logic                out_wr_ptr_ff, out_rd_ptr_ff;
   logic [1:0]          out_count_ff, out_count_in;
   logic                out_full, out_push, out_pop;

   assign vec_len = (cfg.vector_length > VECTOR_LIMIT) ? VECTOR_LIMIT : cfg.vector_length;
   assign groups  = SCNT_W'(vec_len >> QUANT_SHIFT);

   assign stride_prod = PROD_W'(cfg.padded_length) * PROD_W'(q_word.head);
   assign base_in     = {1'b0, stride_prod} + BASE_W'(q_word.pos);

   assign data_prod  = (DATA_W + 1)'(vec_len) * (DATA_W + 1)'(base_ff);
   assign scale_prod = (SCALE_W + 1)'(groups) * (SCALE_W + 1)'(base_ff);

   always_comb begin
      out_word               = '0;
      out_word.status        = work_ff.status;
      out_word.write_pointer = work_ff.write_pointer;
      if (work_ff.addr_ok) begin
         out_word.slot_position = work_ff.pos;
         out_word.layer_out     = work_ff.layer;
         if (cfg.eight_bit_mode) begin
            out_word.data_offset  = data_prod[DATA_W-1:0];
            out_word.scale_offset = {scale_prod[SCALE_W-2:0], 1'b0};
            out_word.scale_count  = groups;
         end else begin
            out_word.data_offset  = {data_prod[DATA_W-2:0], 1'b0};
         end
      end
   end

   assign out_full = out_count_ff == 2'd2;
   assign empty    = out_count_ff == 2'd0;
   assign out_pop  = pop && !empty;

   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      out_push = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            // hold the finished word until the output queue has room
            if (!out_full) begin
               out_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      out_count_in = out_count_ff;
      if (out_push && !out_pop) begin
         out_count_in = out_count_ff + 2'd1;
      end else if (out_pop && !out_push) begin
         out_count_in = out_count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         out_wr_ptr_ff <= 1'b0;
         out_rd_ptr_ff <= 1'b0;
         out_count_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         out_count_ff <= out_count_in;
         if (out_push) begin
            out_wr_ptr_ff <= !out_wr_ptr_ff;
         end
         if (out_pop) begin
            out_rd_ptr_ff <= !out_rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         work_ff <= q_word;
         base_ff <= base_in;
      end
      if (out_push) begin
         out_mem_ff[out_wr_ptr_ff] <= out_word;
      end
   end

   assign rd_word           = out_mem_ff[out_rd_ptr_ff];
   assign rsp_status        = rd_word.status;
   assign rsp_slot_position = rd_word.slot_position;
   assign rsp_layer_out     = rd_word.layer_out;
   assign rsp_data_offset   = rd_word.data_offset;
   assign rsp_scale_offset  = rd_word.scale_offset;
   assign rsp_scale_count   = rd_word.scale_count;
   assign rsp_write_pointer = rd_word.write_pointer;

`ifndef SYNTHESIS
   a_out_count_range: assert property (@(posedge clock) disable iff (reset)
      out_count_ff != 2'd3)
      else $error("output queue count out of range");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == S_IDLE) && !q_empty)
      else $error("command queue popped outside idle");

   a_push_returns_idle: assert property (@(posedge clock) disable iff (reset)
      out_push |=> state_ff == S_IDLE)
      else $error("back end did not return to idle after a result");

   a_failed_word_zero: assert property (@(posedge clock) disable iff (reset)
      out_push && (work_ff.status != ST_OK) |->
         (out_word.data_offset == '0) && (out_word.slot_position == '0)
         && (out_word.scale_count == '0))
      else $error("failed command carries address fields");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/kv_cache_slot_addresser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kv_cache_slot_addresser: KV cache write position and slot offset unit
// Executes read, append, advance, rewind and reset commands against a fill
// position and returns the byte offsets of one head vector and its scales.
// ----------------------------------------------------------------------------
// Both sides behave as queues: push a command word while full is low, pop a
// result word while empty is low; every command gives exactly one result, in
// order. The front end checks a command and updates the fill position in the
// cycle it is pushed, so a following command already sees the new position;
// up to two classified commands wait in a queue for the back end. The back
// end works on one word at a time (slot base multiply-add, then the data
// and scale offset multiplies) and pops no new word until the last one has
// entered the result queue, where two finished words can wait for pop.
// Write the registers only while no word is in flight.
module kv_cache_slot_addresser (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             csr_wr_en,
   input  wire  [kvsa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire  [kvsa_pkg::CSR_DAT_W-1:0]  csr_wdata,
   input  wire                             push,
   output logic                            full,
   input  wire  [kvsa_pkg::CMD_W-1:0]      req_command,
   input  wire  [kvsa_pkg::LAYER_W-1:0]    req_layer_sel,
   input  wire  [kvsa_pkg::HEAD_W-1:0]     req_head_sel,
   input  wire  [kvsa_pkg::POS_W-1:0]      req_target_position,
   output logic                            empty,
   input  wire                             pop,
   output logic [kvsa_pkg::STATUS_W-1:0]   rsp_status,
   output logic [kvsa_pkg::POS_W-1:0]      rsp_slot_position,
   output logic [kvsa_pkg::LAYER_W-1:0]    rsp_layer_out,
   output logic [kvsa_pkg::DATA_W-1:0]     rsp_data_offset,
   output logic [kvsa_pkg::SCALE_W-1:0]    rsp_scale_offset,
   output logic [kvsa_pkg::SCNT_W-1:0]     rsp_scale_count,
   output logic [kvsa_pkg::FILL_W-1:0]     rsp_write_pointer
);
   import kvsa_pkg::*;

   cfg_type      cfg_ff;
   logic         q_full, q_push, q_empty, q_pop;
   mid_word_type wr_word, rd_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_length     <= FILL_W'(1048576);
         cfg_ff.padded_length  <= FILL_W'(1048576);
         cfg_ff.head_count     <= HCNT_W'(8);
         cfg_ff.vector_length  <= VEC_W'(128);
         cfg_ff.eight_bit_mode <= 1'b0;
         cfg_ff.layers_in_use  <= LCNT_W'(1);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MAX_LENGTH:    cfg_ff.max_length     <= csr_wdata[FILL_W-1:0];
            CSR_PADDED_LENGTH: cfg_ff.padded_length  <= csr_wdata[FILL_W-1:0];
            CSR_HEAD_COUNT:    cfg_ff.head_count     <= csr_wdata[HCNT_W-1:0];
            CSR_VECTOR_LENGTH: cfg_ff.vector_length  <= csr_wdata[VEC_W-1:0];
            CSR_EIGHT_BIT:     cfg_ff.eight_bit_mode <= csr_wdata[0];
            CSR_LAYERS:        cfg_ff.layers_in_use  <= csr_wdata[LCNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   kvsa_front u_front (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .push                (push),
      .full                (full),
      .req_command         (req_command),
      .req_layer_sel       (req_layer_sel),
      .req_head_sel        (req_head_sel),
      .req_target_position (req_target_position),
      .q_full              (q_full),
      .q_push              (q_push),
      .q_word              (wr_word)
   );

   kvsa_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_word (wr_word),
      .q_full  (q_full),
      .rd_en   (q_pop),
      .rd_word (rd_word),
      .q_empty (q_empty)
   );

   kvsa_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .q_empty           (q_empty),
      .q_word            (rd_word),
      .q_pop             (q_pop),
      .empty             (empty),
      .pop               (pop),
      .rsp_status        (rsp_status),
      .rsp_slot_position (rsp_slot_position),
      .rsp_layer_out     (rsp_layer_out),
      .rsp_data_offset   (rsp_data_offset),
      .rsp_scale_offset  (rsp_scale_offset),
      .rsp_scale_count   (rsp_scale_count),
      .rsp_write_pointer (rsp_write_pointer)
   );

endmodule
`default_nettype wire
